// ===== rtl/tts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

   localparam int SLOTS       = 8;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int MAX_RESULTS = 8;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_DELETE   = 2'd1,
      OP_TICK     = 2'd2,
      OP_DISPATCH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_NONE  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  task_tag;
      logic [15:0] first_delay;
      logic [15:0] repeat_period;
      logic [2:0]  slot_index;
   } req_type;

   typedef struct packed {
      logic [2:0] result_slot;
      logic [7:0] result_tag;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  tag;
      logic [15:0] delay;
      logic [15:0] period;
      logic [7:0]  pending;
   } slot_rec_type;

   typedef struct packed {
      logic [1:0]        operation;
      logic [7:0]        task_tag;
      logic [15:0]       first_delay;
      logic [15:0]       repeat_period;
      logic [2:0]        slot_index;
      logic [SLOT_W-1:0] slot;
      logic              found;
      logic              room;
   } head_ctl_type;

   typedef struct packed {
      logic emit;
      logic place;
   } head_flag_type;

   function automatic logic [2:0] slot_to_result(input logic [SLOT_W-1:0] slot);
      logic [31:0] wide;
      wide = 32'(slot);
      return wide[2:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tts_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tts_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   shift,
   input  tts_pkg::slot_rec_type rec_in,
   output tts_pkg::slot_rec_type rec_out
);

   tts_pkg::slot_rec_type rec_ff;
   tts_pkg::slot_rec_type rec_in_mux;

   always_comb begin
      rec_in_mux = shift ? rec_in : rec_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
      end else begin
         rec_ff <= rec_in_mux;
      end
   end

   assign rec_out = rec_ff;

endmodule

`default_nettype wire

// ===== rtl/tts_head.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tts_head (
   input  tts_pkg::head_ctl_type  ctl,
   input  tts_pkg::slot_rec_type  rec_in,
   output tts_pkg::slot_rec_type  rec_out,
   output tts_pkg::head_flag_type flags
);

   logic del_hit;

   assign del_hit = (32'(ctl.slot_index) == 32'(ctl.slot));

   always_comb begin
      rec_out     = rec_in;
      flags.emit  = 1'b0;
      flags.place = 1'b0;
      unique case (tts_pkg::op_type'(ctl.operation))
         tts_pkg::OP_ADD: begin
            if (!ctl.found && !rec_in.valid) begin
               rec_out.valid   = 1'b1;
               rec_out.tag     = ctl.task_tag;
               rec_out.delay   = ctl.first_delay;
               rec_out.period  = ctl.repeat_period;
               rec_out.pending = 8'd0;
               flags.place     = 1'b1;
            end
         end
         tts_pkg::OP_DELETE: begin
            if (del_hit) begin
               rec_out = '0;
            end
         end
         tts_pkg::OP_TICK: begin
            if (rec_in.valid) begin
               if (rec_in.delay == 16'd0) begin
                  if (rec_in.pending != 8'hFF) begin
                     rec_out.pending = rec_in.pending + 8'd1;
                  end
                  if (rec_in.period != 16'd0) begin
                     rec_out.delay = rec_in.period - 16'd1;
                  end
               end else begin
                  rec_out.delay = rec_in.delay - 16'd1;
               end
            end
         end
         tts_pkg::OP_DISPATCH: begin
            if (rec_in.valid && rec_in.pending != 8'd0 && ctl.room) begin
               flags.emit      = 1'b1;
               rec_out.pending = rec_in.pending - 8'd1;
               if (rec_in.period == 16'd0) begin
                  rec_out = '0;
               end
            end
         end
         default: begin
            rec_out = rec_in;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/tick_task_scheduler.sv =====
// Channel  | Ports                          | Transaction
// request  | req_valid, req_stall, req_data | one command: add, delete, tick, dispatch
// response | rsp_valid, rsp_stall, rsp_data | one result, last marks the final one
//
// Every command rotates the ring of SLOTS slot cells once through the head unit,
// one slot per cycle while a dispatch is not held by a stalled response register;
// the input stays stalled after the accepting cycle until the command ends.
// A dispatch walk and the final result wait while the response register is full and stalled.
// Reset is synchronous and empties the table; no clearing pass is needed.
// A new command is taken while the previous final result still waits in rsp.
`timescale 1ns / 1ps
`default_nettype none

module tick_task_scheduler (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  tts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output tts_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_WALK = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   tts_pkg::req_type           req_ff, req_in;
   logic [tts_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic                       found_ff, found_in;
   logic [2:0]                 found_slot_ff, found_slot_in;
   logic [tts_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       held_valid_ff, held_valid_in;
   logic [2:0]                 held_slot_ff, held_slot_in;
   logic [7:0]                 held_tag_ff, held_tag_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   tts_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                   out_free;
   logic                   accept;
   logic                   step;
   logic                   rsp_load;
   logic                   in_range;
   tts_pkg::head_ctl_type  head_ctl;
   tts_pkg::head_flag_type head_flags;
   tts_pkg::slot_rec_type  head_rec;
   tts_pkg::slot_rec_type  cell_rec [tts_pkg::SLOTS];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign step      = (state_ff == S_WALK)
                      && ((req_ff.operation != tts_pkg::OP_DISPATCH) || out_free);
   assign in_range  = ({29'd0, req_ff.slot_index} < 32'(tts_pkg::SLOTS));

   always_comb begin
      head_ctl.operation     = req_ff.operation;
      head_ctl.task_tag      = req_ff.task_tag;
      head_ctl.first_delay   = req_ff.first_delay;
      head_ctl.repeat_period = req_ff.repeat_period;
      head_ctl.slot_index    = req_ff.slot_index;
      head_ctl.slot          = slot_ff;
      head_ctl.found         = found_ff;
      head_ctl.room          = (count_ff < tts_pkg::CNT_W'(tts_pkg::MAX_RESULTS));
   end

   tts_head u_head (
      .ctl     (head_ctl),
      .rec_in  (cell_rec[0]),
      .rec_out (head_rec),
      .flags   (head_flags)
   );

   for (genvar i = 0; i < tts_pkg::SLOTS; i++) begin : g_cell
      if (i == tts_pkg::SLOTS - 1) begin : g_tail
         tts_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (step),
            .rec_in  (head_rec),
            .rec_out (cell_rec[i])
         );
      end else begin : g_body
         tts_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (step),
            .rec_in  (cell_rec[i+1]),
            .rec_out (cell_rec[i])
         );
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      slot_in       = slot_ff;
      found_in      = found_ff;
      found_slot_in = found_slot_ff;
      count_in      = count_ff;
      held_valid_in = held_valid_ff;
      held_slot_in  = held_slot_ff;
      held_tag_in   = held_tag_ff;
      rsp_load      = 1'b0;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in      = S_WALK;
               req_in        = req_data;
               slot_in       = '0;
               found_in      = 1'b0;
               count_in      = '0;
               held_valid_in = 1'b0;
            end
         end
         S_WALK: begin
            if (step) begin
               slot_in = slot_ff + tts_pkg::SLOT_W'(1);
               if (head_flags.place) begin
                  found_in      = 1'b1;
                  found_slot_in = tts_pkg::slot_to_result(slot_ff);
               end
               if (head_flags.emit) begin
                  count_in      = count_ff + tts_pkg::CNT_W'(1);
                  held_valid_in = 1'b1;
                  held_slot_in  = tts_pkg::slot_to_result(slot_ff);
                  held_tag_in   = cell_rec[0].tag;
                  if (held_valid_ff) begin
                     rsp_load                = 1'b1;
                     rsp_data_in.result_slot = held_slot_ff;
                     rsp_data_in.result_tag  = held_tag_ff;
                     rsp_data_in.status      = tts_pkg::ST_OK;
                     rsp_data_in.last        = 1'b0;
                  end
               end
               if (slot_ff == tts_pkg::SLOT_W'(tts_pkg::SLOTS - 1)) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (req_ff.operation == tts_pkg::OP_TICK) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               state_in                = S_IDLE;
               rsp_load                = 1'b1;
               rsp_data_in.result_tag  = 8'd0;
               rsp_data_in.last        = 1'b1;
               unique case (tts_pkg::op_type'(req_ff.operation))
                  tts_pkg::OP_ADD: begin
                     rsp_data_in.result_slot = found_ff ? found_slot_ff : 3'd0;
                     rsp_data_in.status      = found_ff ? tts_pkg::ST_OK : tts_pkg::ST_FULL;
                  end
                  tts_pkg::OP_DELETE: begin
                     rsp_data_in.result_slot = req_ff.slot_index;
                     rsp_data_in.status      = in_range ? tts_pkg::ST_OK : tts_pkg::ST_RANGE;
                  end
                  tts_pkg::OP_DISPATCH: begin
                     if (held_valid_ff) begin
                        rsp_data_in.result_slot = held_slot_ff;
                        rsp_data_in.result_tag  = held_tag_ff;
                        rsp_data_in.status      = tts_pkg::ST_OK;
                     end else begin
                        rsp_data_in.result_slot = 3'd0;
                        rsp_data_in.status      = tts_pkg::ST_NONE;
                     end
                     held_valid_in = 1'b0;
                  end
                  default: begin
                     rsp_data_in.result_slot = 3'd0;
                     rsp_data_in.status      = tts_pkg::ST_NONE;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         found_ff      <= 1'b0;
         count_ff      <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         slot_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         found_ff      <= found_in;
         count_ff      <= count_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         slot_ff       <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      found_slot_ff <= found_slot_in;
      held_slot_ff  <= held_slot_in;
      held_tag_ff   <= held_tag_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_walk_pause_only_dispatch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && !step) |-> (req_ff.operation == tts_pkg::OP_DISPATCH))
      else $error("Walk paused outside a dispatch.");

   a_held_only_dispatch: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> (req_ff.operation == tts_pkg::OP_DISPATCH && state_ff != S_IDLE))
      else $error("Held result outside a dispatch.");

   a_last_ends_command: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_data_in.last) |=> (state_ff == S_IDLE))
      else $error("Final result loaded but command not finished.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tts_pkg::CNT_W'(tts_pkg::MAX_RESULTS))
      else $error("Dispatch produced too many results.");

   a_no_load_over_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("Response register overwritten while stalled.");
`endif

endmodule

`default_nettype wire
